// File: rtl/core/lrt_pkg.sv
`timescale 1ns / 1ps

package lrt_pkg;

	// sequence length and field widths
	localparam int SEQ_LEN = 40;
	localparam int CNT_W   = 13;
	localparam int GEN_W   = 31;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ARG_W   = 24;
	localparam int D2_W    = 48;
	localparam int QH_W    = 14;
	localparam int C1_W    = 26;
	localparam int ACC_W   = 76;

	localparam logic [CNT_W-1:0] SEQ_LEN_C = CNT_W'(SEQ_LEN);
	localparam logic [MUL_W-1:0] LCG_MUL   = 32'd1103515245;
	localparam logic [GEN_W-1:0] LCG_ADD   = 31'd12345;
	localparam logic [MUL_W-1:0] K_LHS     = 32'd10000;
	localparam logic [MUL_W-1:0] K_RHS     = 32'd38416;

	// microprogram geometry
	localparam int UC_DEPTH = 23;
	localparam int UPC_W    = $clog2(UC_DEPTH);
	localparam logic [UPC_W-1:0] UA_FETCH = 5'd0;
	localparam logic [UPC_W-1:0] UA_WRITE = 5'd22;

	typedef enum logic [3:0] {
		OP_FETCH,
		OP_MUL,
		OP_LCG,
		OP_LD_A,
		OP_LD_P,
		OP_LD_D2,
		OP_LD_Q,
		OP_RHS_LO,
		OP_RHS_HI,
		OP_LD_C,
		OP_LHS_LO,
		OP_LHS_HI,
		OP_DECIDE,
		OP_WRITE
	} uop_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_WAIT_IN,
		C_NOT_LAST,
		C_WAIT_OUT,
		C_JUMP
	} ucond_t;

	typedef struct packed {
		uop_t             op;
		ucond_t           cond;
		logic [UPC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		uop_t op;
		logic fire;
		logic restart;
	} lrt_ctrl_t;

	typedef struct packed {
		logic last_next;
		logic verdict;
	} lrt_stat_t;

	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucode_t uw;
		case (upc)
			5'd0:  uw = '{op: OP_FETCH,  cond: C_WAIT_IN,  target: UA_FETCH};
			5'd1:  uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd2:  uw = '{op: OP_LCG,    cond: C_NOT_LAST, target: UA_WRITE};
			5'd3:  uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd4:  uw = '{op: OP_LD_A,   cond: C_NEXT,     target: UA_FETCH};
			5'd5:  uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd6:  uw = '{op: OP_LD_P,   cond: C_NEXT,     target: UA_FETCH};
			5'd7:  uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd8:  uw = '{op: OP_LD_D2,  cond: C_NEXT,     target: UA_FETCH};
			5'd9:  uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd10: uw = '{op: OP_LD_Q,   cond: C_NEXT,     target: UA_FETCH};
			5'd11: uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd12: uw = '{op: OP_RHS_LO, cond: C_NEXT,     target: UA_FETCH};
			5'd13: uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd14: uw = '{op: OP_RHS_HI, cond: C_NEXT,     target: UA_FETCH};
			5'd15: uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd16: uw = '{op: OP_LD_C,   cond: C_NEXT,     target: UA_FETCH};
			5'd17: uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd18: uw = '{op: OP_LHS_LO, cond: C_NEXT,     target: UA_FETCH};
			5'd19: uw = '{op: OP_MUL,    cond: C_NEXT,     target: UA_FETCH};
			5'd20: uw = '{op: OP_LHS_HI, cond: C_NEXT,     target: UA_FETCH};
			5'd21: uw = '{op: OP_DECIDE, cond: C_NEXT,     target: UA_FETCH};
			5'd22: uw = '{op: OP_WRITE,  cond: C_WAIT_OUT, target: UA_FETCH};
			default: uw = '{op: OP_MUL,  cond: C_JUMP,     target: UA_FETCH};
		endcase
		return uw;
	endfunction

endpackage

// File: rtl/core/lrt_datapath.sv
`timescale 1ns / 1ps

module lrt_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lrt_pkg::lrt_ctrl_t        ctrl,
	input  logic [lrt_pkg::GEN_W-1:0] seed,
	output lrt_pkg::lrt_stat_t        stat,
	output logic [lrt_pkg::GEN_W-1:0] random_value,
	output logic                      high_bit,
	output logic                      is_last,
	output logic [lrt_pkg::CNT_W-1:0] run_count,
	output logic [lrt_pkg::CNT_W-1:0] high_count,
	output logic [lrt_pkg::CNT_W-1:0] low_count,
	output logic                      accepted
);
	import lrt_pkg::*;

	// generator and sequence counters
	logic [GEN_W-1:0]  gen_q;
	logic              prev_q;
	logic [CNT_W-1:0]  runs_q, ones_q, zeros_q, pos_q;

	// shared multiplier and verdict scratch
	logic [MUL_W-1:0]  m_a_q, m_b_q;
	logic [PROD_W-1:0] prod_q;
	logic [ARG_W-1:0]  a_q, p_q;
	logic [D2_W-1:0]   d2_q;
	logic [QH_W-1:0]   qh_q;
	logic [C1_W-1:0]   c1_q;
	logic [ACC_W-1:0]  lhs_q, rhs_q;
	logic              last_q, verdict_q;

	logic [PROD_W-1:0] mul_full;
	logic [GEN_W-1:0]  lcg_sum;
	logic              new_bit;
	logic [CNT_W-1:0]  pos_inc, runs_nxt;
	logic [ARG_W-1:0]  p_new, d_new, n_ext;

	assign mul_full = m_a_q * m_b_q;
	assign lcg_sum  = prod_q[GEN_W-1:0] + LCG_ADD;
	assign new_bit  = lcg_sum[GEN_W-1];
	assign pos_inc  = pos_q + CNT_W'(1);
	assign n_ext    = ARG_W'(pos_q);
	assign p_new    = {prod_q[ARG_W-2:0], 1'b0};

	always_comb begin
		if (pos_q == '0) begin
			runs_nxt = CNT_W'(1);
		end else if (new_bit != prev_q) begin
			runs_nxt = runs_q + CNT_W'(1);
		end else begin
			runs_nxt = runs_q;
		end
		if (a_q >= p_new) begin
			d_new = a_q - p_new;
		end else begin
			d_new = p_new - a_q;
		end
	end

	assign stat.last_next = (pos_inc >= SEQ_LEN_C);
	assign stat.verdict   = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q   <= '0;
			prev_q  <= 1'b0;
			runs_q  <= '0;
			ones_q  <= '0;
			zeros_q <= '0;
			pos_q   <= '0;
		end else begin
			case (ctrl.op)
				OP_FETCH: begin
					if (ctrl.fire && ctrl.restart) begin
						prev_q  <= 1'b0;
						runs_q  <= '0;
						ones_q  <= '0;
						zeros_q <= '0;
						pos_q   <= '0;
					end
				end
				OP_LCG: begin
					gen_q  <= lcg_sum;
					prev_q <= new_bit;
					runs_q <= runs_nxt;
					pos_q  <= pos_inc;
					if (new_bit) begin
						ones_q <= ones_q + CNT_W'(1);
					end else begin
						zeros_q <= zeros_q + CNT_W'(1);
					end
				end
				OP_WRITE: begin
					// start a fresh sequence once the verdict word is out
					if (ctrl.fire && last_q) begin
						prev_q  <= 1'b0;
						runs_q  <= '0;
						ones_q  <= '0;
						zeros_q <= '0;
						pos_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_FETCH: begin
				m_a_q <= ctrl.restart ? MUL_W'(seed) : MUL_W'(gen_q);
				m_b_q <= LCG_MUL;
			end
			OP_MUL: begin
				prod_q <= mul_full;
			end
			OP_LCG: begin
				last_q <= stat.last_next;
				m_a_q  <= MUL_W'(pos_inc);
				m_b_q  <= MUL_W'(runs_nxt - CNT_W'(1));
			end
			OP_LD_A: begin
				a_q   <= prod_q[ARG_W-1:0];
				m_a_q <= MUL_W'(ones_q);
				m_b_q <= MUL_W'(zeros_q);
			end
			OP_LD_P: begin
				p_q   <= p_new;
				m_a_q <= MUL_W'(d_new);
				m_b_q <= MUL_W'(d_new);
			end
			OP_LD_D2: begin
				d2_q  <= prod_q[D2_W-1:0];
				m_a_q <= MUL_W'(p_q);
				m_b_q <= MUL_W'(p_q - n_ext);
			end
			OP_LD_Q: begin
				qh_q  <= prod_q[MUL_W+QH_W-1:MUL_W];
				m_a_q <= prod_q[MUL_W-1:0];
				m_b_q <= K_RHS;
			end
			OP_RHS_LO: begin
				rhs_q <= ACC_W'(prod_q);
				m_a_q <= MUL_W'(qh_q);
				m_b_q <= K_RHS;
			end
			OP_RHS_HI: begin
				rhs_q <= rhs_q + {prod_q[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
				m_a_q <= MUL_W'(pos_q - CNT_W'(1));
				m_b_q <= K_LHS;
			end
			OP_LD_C: begin
				c1_q  <= prod_q[C1_W-1:0];
				m_a_q <= d2_q[MUL_W-1:0];
				m_b_q <= prod_q[MUL_W-1:0];
			end
			OP_LHS_LO: begin
				lhs_q <= ACC_W'(prod_q);
				m_a_q <= MUL_W'(d2_q[D2_W-1:MUL_W]);
				m_b_q <= MUL_W'(c1_q);
			end
			OP_LHS_HI: begin
				lhs_q <= lhs_q + {prod_q[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
			end
			OP_DECIDE: begin
				// reject on an empty class or zero variance
				verdict_q <= (ones_q != '0) && (zeros_q != '0) && (p_q > n_ext)
					&& (lhs_q <= rhs_q);
			end
			OP_WRITE: begin
				if (ctrl.fire) begin
					random_value <= gen_q;
					high_bit     <= prev_q;
					is_last      <= last_q;
					run_count    <= runs_q;
					high_count   <= ones_q;
					low_count    <= zeros_q;
					accepted     <= last_q & verdict_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/lcg_runs_test.sv
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in       in         in_valid / in_stall    restart
// out      out        out_valid / out_stall  random_value, high_bit, is_last, counts, accepted
// cfg      in         cfg_we                 cfg_wdata (seed)
//
// An ordinary word goes fetch, multiply, generator step, write; the last word of a sequence
// also runs the verdict steps before the write, as the verdict products run one at a time
// through the shared 32x32 multiplier under the microprogram.
// Reset clears the seed, the generator, the counts and the program counter.
// A finished word waits in the output register; the next input word is still taken,
// and the write step holds only while that register is full and stalled.
module lcg_runs_test (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lrt_pkg::GEN_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lrt_pkg::GEN_W-1:0] random_value,
	output logic                      high_bit,
	output logic                      is_last,
	output logic [lrt_pkg::CNT_W-1:0] run_count,
	output logic [lrt_pkg::CNT_W-1:0] high_count,
	output logic [lrt_pkg::CNT_W-1:0] low_count,
	output logic                      accepted
);
	import lrt_pkg::*;

	logic [GEN_W-1:0] seed_q;
	logic [UPC_W-1:0] upc_q, upc_nxt;
	logic             out_valid_q;
	ucode_t           uw;
	lrt_ctrl_t        ctrl;
	lrt_stat_t        stat;
	logic             out_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	assign uw        = ucode_rom(upc_q);
	assign out_block = out_valid_q && out_stall;
	assign in_stall  = (upc_q != UA_FETCH);

	always_comb begin
		ctrl.op      = uw.op;
		ctrl.restart = restart;
		ctrl.fire    = 1'b1;
		upc_nxt      = upc_q + UPC_W'(1);
		case (uw.cond)
			C_NEXT: begin
			end
			C_WAIT_IN: begin
				ctrl.fire = in_valid;
				if (!in_valid) begin
					upc_nxt = upc_q;
				end
			end
			C_NOT_LAST: begin
				if (!stat.last_next) begin
					upc_nxt = uw.target;
				end
			end
			C_WAIT_OUT: begin
				ctrl.fire = !out_block;
				upc_nxt   = out_block ? upc_q : uw.target;
			end
			C_JUMP: begin
				upc_nxt = uw.target;
			end
			default: begin
				upc_nxt = UA_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UA_FETCH;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_nxt;
			if (uw.op == OP_WRITE && ctrl.fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	lrt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.seed         (seed_q),
		.stat         (stat),
		.random_value (random_value),
		.high_bit     (high_bit),
		.is_last      (is_last),
		.run_count    (run_count),
		.high_count   (high_count),
		.low_count    (low_count),
		.accepted     (accepted)
	);

	// an accepted word always moves the program on to the multiply
	a_fetch_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> upc_q == UA_FETCH + UPC_W'(1))
		else $error("sequencer did not leave fetch after accepting a word");

	// a full, stalled output register holds the program at the write step
	a_write_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == UA_WRITE && out_valid_q && out_stall |=> upc_q == UA_WRITE)
		else $error("result overwritten while output stalled");

	// the program counter never leaves the table
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= UA_WRITE)
		else $error("program counter outside microprogram");

	// the closing word of a sequence carries exactly the sequence length
	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> (14'(high_count) + 14'(low_count)) == 14'(SEQ_LEN))
		else $error("class counts do not add up on the last word");

	// a verdict is given only with the last word
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> is_last)
		else $error("accept flag set on a word that is not last");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import lrt_pkg::*;

	typedef struct packed {
		logic [GEN_W-1:0] random_value;
		logic             high_bit;
		logic             is_last;
		logic [CNT_W-1:0] run_count;
		logic [CNT_W-1:0] high_count;
		logic [CNT_W-1:0] low_count;
		logic             accepted;
	} tick_t;

	class runs_scoreboard;
		logic [GEN_W-1:0] seed_reg;
		logic [GEN_W-1:0] gen;
		logic             prev_bit;
		logic [CNT_W-1:0] runs;
		logic [CNT_W-1:0] ones;
		logic [CNT_W-1:0] zeros;
		logic [CNT_W-1:0] pos;
		tick_t            expected_ticks[$];
		int               fail_count;
		int               n_ticks;
		int               n_restarts;
		int               n_checked;
		int               n_seq_ends;
		int               n_verdict_pass;

		function new();
			seed_reg = '0;
			gen = '0;
			clear_counts();
		endfunction

		function void clear_counts();
			prev_bit = 1'b0;
			runs = '0;
			ones = '0;
			zeros = '0;
			pos = '0;
		endfunction

		function void set_seed(logic [GEN_W-1:0] v);
			seed_reg = v;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		// exact integer form of |Z| <= 1.96
		function bit runs_verdict(longint unsigned n1, longint unsigned n2,
				longint unsigned r);
			longint unsigned n, p, a, d, lhs, rhs;
			if (n1 == 0 || n2 == 0 || r == 0)
				return 1'b0;
			n = n1 + n2;
			p = 2 * n1 * n2;
			// one of each value gives zero variance: reject
			if (p <= n)
				return 1'b0;
			a = n * (r - 1);
			d = (a >= p) ? a - p : p - a;
			lhs = 64'd10000 * d * d;
			rhs = 64'd38416 * p * (p - n);
			return lhs <= rhs / (n - 1);
		endfunction

		function void note_tick(bit rst);
			tick_t           t;
			logic [63:0]     prod;
			logic            b;
			n_ticks++;
			if (rst) begin
				n_restarts++;
				gen = seed_reg;
				clear_counts();
			end
			prod = 64'(LCG_MUL) * 64'(gen) + 64'(LCG_ADD);
			gen = prod[GEN_W-1:0];
			b = gen[GEN_W-1];
			if (pos == 0)
				runs = CNT_W'(1);
			else if (b != prev_bit)
				runs = runs + 1'b1;
			if (b)
				ones = ones + 1'b1;
			else
				zeros = zeros + 1'b1;
			prev_bit = b;
			pos = pos + 1'b1;
			t.random_value = gen;
			t.high_bit = b;
			t.is_last = (pos >= SEQ_LEN_C);
			t.run_count = runs;
			t.high_count = ones;
			t.low_count = zeros;
			t.accepted = t.is_last ? runs_verdict(ones, zeros, runs) : 1'b0;
			expected_ticks.insert(expected_ticks.size(), t);
			if (t.is_last)
				clear_counts();
		endfunction

		task report(string what, longint unsigned got, longint unsigned exp_v);
			fail_count++;
			if (fail_count <= 30)
				$display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, exp_v);
		endtask

		task check_tick(tick_t got);
			tick_t e;
			if (expected_ticks.size() == 0) begin
				report("result with nothing pending", got.random_value, 0);
				return;
			end
			e = expected_ticks.pop_front();
			n_checked++;
			if (e.is_last) begin
				n_seq_ends++;
				if (e.accepted)
					n_verdict_pass++;
			end
			if (got.random_value !== e.random_value)
				report("random_value", got.random_value, e.random_value);
			if (got.high_bit !== e.high_bit)
				report("high_bit", got.high_bit, e.high_bit);
			if (got.is_last !== e.is_last)
				report("is_last", got.is_last, e.is_last);
			if (got.run_count !== e.run_count)
				report("run_count", got.run_count, e.run_count);
			if (got.high_count !== e.high_count)
				report("high_count", got.high_count, e.high_count);
			if (got.low_count !== e.low_count)
				report("low_count", got.low_count, e.low_count);
			if (got.accepted !== e.accepted)
				report("accepted", got.accepted, e.accepted);
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [GEN_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              restart = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [GEN_W-1:0]  random_value;
	logic              high_bit;
	logic              is_last;
	logic [CNT_W-1:0]  run_count;
	logic [CNT_W-1:0]  high_count;
	logic [CNT_W-1:0]  low_count;
	logic              accepted;

	runs_scoreboard sb = new();
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int hold_req = 0;
	int n_seeds = 0;

	lcg_runs_test uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value),
		.high_bit     (high_bit),
		.is_last      (is_last),
		.run_count    (run_count),
		.high_count   (high_count),
		.low_count    (low_count),
		.accepted     (accepted)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_tick(bit rst);
		in_valid <= 1'b1;
		restart <= rst;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_tick(rst);
	endtask

	task automatic send_and_idle(bit rst);
		int gap;
		send_tick(rst);
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_seed(logic [GEN_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_seed(v);
		n_seeds++;
	endtask

	// receiver: check, then pick the stall for the next edge
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_tick('{random_value, high_bit, is_last, run_count,
					high_count, low_count, accepted});
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(rx_quiet);
			end
		end
	end

	initial begin
		#20000000;
		$display("Timeout waiting for results");
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int phase;
		int len;
		logic [GEN_W-1:0] s;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset seed, extreme seeds, restart mid-sequence
		send_and_idle(1'b0);
		send_and_idle(1'b0);
		send_and_idle(1'b1);
		drain();
		write_seed(31'h7FFF_FFFF);
		send_and_idle(1'b1);
		repeat (3) send_and_idle(1'b0);
		send_and_idle(1'b1);
		repeat (2) send_and_idle(1'b0);
		drain();
		write_seed(31'h4000_0000);
		send_and_idle(1'b1);
		repeat (3) send_and_idle(1'b0);
		drain();
		write_seed(31'h2AAA_AAAA);
		send_and_idle(1'b1);
		send_and_idle(1'b0);
		drain();
		write_seed(31'h5555_5555);
		send_and_idle(1'b1);
		send_and_idle(1'b0);
		drain();
		write_seed(31'h0);
		send_and_idle(1'b1);

		// random phases, each from a fresh seed
		phase = 0;
		while (sb.n_ticks < 650) begin
			drain();
			case (phase % 6)
				0: s = 31'h0;
				3: s = 31'h7FFF_FFFF;
				default: s = GEN_W'($urandom());
			endcase
			write_seed(s);
			tx_quiet = (phase % 4 == 1);
			rx_quiet = (phase % 5 == 2);
			len = $urandom_range(40, 130);
			if (phase == 2) begin
				// hold the output long enough for the block to back up
				tx_quiet = 1'b1;
				hold_req = 300;
				repeat (20) send_and_idle(1'b0);
				tx_quiet = 1'b0;
			end
			send_and_idle($urandom_range(0, 3) != 0);
			repeat (len) begin
				if (phase == 3 && len-- == 60)
					drain();
				send_and_idle($urandom_range(0, 149) == 0);
			end
			phase++;
		end

		drain();
		repeat (40) @(posedge clk);
		while (sb.pending() > 0) begin
			sb.report("result never arrived", 0, sb.expected_ticks[0].random_value);
			void'(sb.expected_ticks.pop_front());
		end
		$display("Sent %0d words (%0d restarts) over %0d seeds; %0d results checked.",
			sb.n_ticks, sb.n_restarts, n_seeds, sb.n_checked);
		$display("%0d sequences reached their verdict, %0d of them judged random.",
			sb.n_seq_ends, sb.n_verdict_pass);
		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/core/lrt_pkg.sv
rtl/core/lrt_datapath.sv
rtl/core/lcg_runs_test.sv
sim/tb_top.sv
